// ===== design/tlw_pkg.sv =====
package tlw_pkg;

  // Input item, last declared field in the lowest bits.
  typedef struct packed {
    logic [2:0]  pad;
    logic [31:0] now_tick;
    logic        demoted;
    logic [31:0] enter_tick;
    logic [31:0] runtime_value;
    logic        entered;
    logic [2:0]  task_id;
  } in_item_t;

  // Result item, last declared field in the lowest bits.
  typedef struct packed {
    logic        pad;
    logic [7:0]  error_total;
    logic [2:0]  task_number;
    logic [1:0]  fault_kind;
    logic        fault;
    logic        refresh;
  } out_item_t;

  localparam int IN_DATA_W  = $bits(in_item_t);
  localparam int OUT_DATA_W = $bits(out_item_t);
  localparam int NUM_W      = 3;

  // One task record as held in the record memory.
  typedef struct packed {
    logic [7:0]  err_count;
    logic [31:0] start;
    logic [31:0] runtime;
  } row_t;

  localparam int ROW_W = $bits(row_t);

  // First hits found by the scan.
  typedef struct packed {
    logic ovr;
    logic stl;
  } hit_t;

  typedef enum logic [1:0] {
    KIND_NONE       = 2'd0,
    KIND_OVERRUN    = 2'd1,
    KIND_STALL      = 2'd2,
    KIND_NO_CULPRIT = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    CFG_MAX_RUNTIME   = 2'd0,
    CFG_MAX_ELAPSED   = 2'd1,
    CFG_SETTLE_CHECKS = 2'd2,
    CFG_UNUSED        = 2'd3
  } cfg_idx_t;

  localparam logic [31:0] RST_MAX_RUNTIME = 32'd10;
  localparam logic [31:0] RST_MAX_ELAPSED = 32'd60;
  localparam logic [1:0]  RST_SETTLE      = 2'd3;
  localparam logic [7:0]  ERR_MAX         = 8'hFF;

endpackage

// ===== design/tlw_ram.sv =====
module tlw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/tlw_scan.sv =====
module tlw_scan #(
  parameter int TASKS = 5,
  localparam int AW = (TASKS > 1) ? $clog2(TASKS) : 1
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               clear,
  input  logic               eval,
  input  logic [AW-1:0]      eval_idx,
  input  tlw_pkg::row_t      row,
  input  logic               row_ok,
  input  logic               rt_ok,
  input  logic               demoted,
  input  logic [31:0]        max_runtime,
  input  logic [31:0]        max_elapsed,
  input  logic [31:0]        now_tick,
  output tlw_pkg::hit_t      hits,
  output logic [AW-1:0]      ovr_idx,
  output logic [AW-1:0]      stl_idx
);

  logic [31:0] runtime;
  logic [31:0] start;
  logic [31:0] elapsed;
  logic        overrun;
  logic        stalled;

  // Unwritten records and cleared runtimes read as zero.
  assign runtime = (row_ok && rt_ok) ? row.runtime : '0;
  assign start   = row_ok ? row.start : '0;
  assign elapsed = now_tick - start;
  assign overrun = !demoted && (runtime > max_runtime);
  assign stalled = !demoted && (elapsed > max_elapsed);

  // Keep the first task of each kind.
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      hits <= '0;
    end else if (eval) begin
      hits <= '{ovr: hits.ovr || overrun, stl: hits.stl || stalled};
    end
  end

  always_ff @(posedge clk) begin
    if (eval && !hits.ovr && overrun) begin
      ovr_idx <= eval_idx;
    end
    if (eval && !hits.stl && stalled) begin
      stl_idx <= eval_idx;
    end
  end

endmodule

// ===== design/task_liveness_watchdog_monitor_unit.sv =====
// Task report: record written in the cycle after acceptance, then back to idle.
// Passing check: S_OUT moves the result to the output register once it is free.
// Failing check: the scan reads one record of the record RAM per cycle (S_SCAN,
// S_SCAN_LAST), then S_DECIDE, S_FIX_WR (skipped with no culprit) and S_OUT follow.
// A result may wait in the output register while the next item is accepted.
// rst (synchronous) clears marks, flags, halt and output; registers load 10, 60, 3.
module task_liveness_watchdog_monitor_unit #(
  parameter int TASKS = 5
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // task_id[2:0], entered[3], runtime_value[35:4], enter_tick[67:36],
  // demoted[68], now_tick[100:69], zero fill[103:101]
  input  logic [tlw_pkg::IN_DATA_W-1:0]  s_tdata,
  // req_type[0]
  input  logic                           s_tuser,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // refresh[0], fault[1], fault_kind[3:2], task_number[6:4],
  // error_total[14:7], zero fill[15]
  output logic [tlw_pkg::OUT_DATA_W-1:0] m_tdata,
  input  logic                           cfg_we,
  input  logic [1:0]                     cfg_addr,
  input  logic [31:0]                    cfg_wdata
);

  localparam int AW = (TASKS > 1) ? $clog2(TASKS) : 1;

  typedef enum logic [6:0] {
    S_IDLE      = 7'b0000001,
    S_REP_WR    = 7'b0000010,
    S_SCAN      = 7'b0000100,
    S_SCAN_LAST = 7'b0001000,
    S_DECIDE    = 7'b0010000,
    S_FIX_WR    = 7'b0100000,
    S_OUT       = 7'b1000000
  } state_t;

  state_t state;
  state_t state_next;

  tlw_pkg::in_item_t  in_item;
  tlw_pkg::out_item_t out_q;
  tlw_pkg::out_item_t res;
  tlw_pkg::row_t      rdata;
  tlw_pkg::row_t      wdata;
  tlw_pkg::hit_t      hits;

  // Configuration registers.
  logic [31:0] max_runtime;
  logic [31:0] max_elapsed;
  logic [1:0]  settle_left;

  // Per-task flags kept in flops; the wide fields live in the record RAM.
  logic [TASKS-1:0] entered_mark;
  logic [TASKS-1:0] demoted_flag;
  logic [TASKS-1:0] row_valid;
  logic [TASKS-1:0] rt_valid;
  logic             halted;

  // Latched item.
  logic [AW-1:0] it_id;
  logic          it_entered;
  logic [31:0]   it_runtime;
  logic [31:0]   it_start;
  logic          it_demoted;
  logic [31:0]   now_q;

  logic [AW-1:0] scan_idx;
  logic          eval_q;
  logic [AW-1:0] eval_idx_q;
  logic [AW-1:0] ovr_idx;
  logic [AW-1:0] stl_idx;
  logic [AW-1:0] blame_idx;
  logic [AW-1:0] blame_q;
  logic [1:0]    kind_q;

  logic          accept;
  logic          is_check;
  logic          id_ok;
  logic [AW-1:0] id_addr;
  logic          pass;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [AW-1:0] ram_raddr;
  logic [7:0]    err_cur;
  logic [7:0]    err_inc;
  logic          out_free;

  assign in_item  = tlw_pkg::in_item_t'(s_tdata);
  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign is_check = s_tuser;
  assign id_ok    = 32'(in_item.task_id) < 32'(TASKS);
  assign id_addr  = AW'(in_item.task_id);
  assign m_tdata  = out_q;
  assign out_free = !m_tvalid || m_tready;

  // Check passes while settling, or when every task entered or is demoted.
  assign pass = (settle_left != 2'd0) || (&(entered_mark | demoted_flag));

  // Overrun beats stall; the scan kept the first task of each.
  assign blame_idx = hits.ovr ? ovr_idx : stl_idx;

  assign err_cur = row_valid[blame_q] ? rdata.err_count : 8'd0;
  assign err_inc = (err_cur == tlw_pkg::ERR_MAX) ? err_cur : err_cur + 8'd1;

  // Record RAM port control.
  always_comb begin
    ram_raddr = scan_idx;
    ram_we    = 1'b0;
    ram_waddr = it_id;
    wdata     = rdata;
    unique case (state)
      S_IDLE:   ram_raddr = id_addr;
      S_DECIDE: ram_raddr = blame_idx;
      S_REP_WR: begin
        // Merge the report into the record just read.
        ram_we            = 1'b1;
        ram_waddr         = it_id;
        wdata.err_count   = row_valid[it_id] ? rdata.err_count : 8'd0;
        wdata.start       = it_entered ? it_start :
                            (row_valid[it_id] ? rdata.start : 32'd0);
        wdata.runtime     = it_runtime;
      end
      S_FIX_WR: begin
        // Write back the blamed task's bumped error count.
        ram_we            = 1'b1;
        ram_waddr         = blame_q;
        wdata.err_count   = err_inc;
        wdata.start       = row_valid[blame_q] ? rdata.start : 32'd0;
        wdata.runtime     = (row_valid[blame_q] && rt_valid[blame_q]) ?
                            rdata.runtime : 32'd0;
      end
      default: ram_raddr = scan_idx;
    endcase
  end

  tlw_ram #(
    .WIDTH (tlw_pkg::ROW_W),
    .DEPTH (TASKS)
  ) u_rec_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (wdata),
    .raddr (ram_raddr),
    .rdata (rdata)
  );

  // Evaluate each record in the cycle after its read.
  tlw_scan #(
    .TASKS (TASKS)
  ) u_scan (
    .clk         (clk),
    .rst         (rst),
    .clear       (accept && is_check),
    .eval        (eval_q),
    .eval_idx    (eval_idx_q),
    .row         (rdata),
    .row_ok      (row_valid[eval_idx_q]),
    .rt_ok       (rt_valid[eval_idx_q]),
    .demoted     (demoted_flag[eval_idx_q]),
    .max_runtime (max_runtime),
    .max_elapsed (max_elapsed),
    .now_tick    (now_q),
    .hits        (hits),
    .ovr_idx     (ovr_idx),
    .stl_idx     (stl_idx)
  );

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept && !halted) begin
          if (!is_check) begin
            if (id_ok) begin
              state_next = S_REP_WR;
            end
          end else if (pass) begin
            state_next = S_OUT;
          end else begin
            state_next = S_SCAN;
          end
        end
      end
      S_REP_WR: state_next = S_IDLE;
      S_SCAN: begin
        if (scan_idx == AW'(TASKS - 1)) begin
          state_next = S_SCAN_LAST;
        end
      end
      S_SCAN_LAST: state_next = S_DECIDE;
      S_DECIDE: begin
        if (hits.ovr || hits.stl) begin
          state_next = S_FIX_WR;
        end else begin
          state_next = S_OUT;
        end
      end
      S_FIX_WR: state_next = S_OUT;
      S_OUT: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      max_runtime  <= tlw_pkg::RST_MAX_RUNTIME;
      max_elapsed  <= tlw_pkg::RST_MAX_ELAPSED;
      settle_left  <= tlw_pkg::RST_SETTLE;
      entered_mark <= '0;
      demoted_flag <= '0;
      row_valid    <= '0;
      rt_valid     <= '0;
      halted       <= 1'b0;
      m_tvalid     <= 1'b0;
      eval_q       <= 1'b0;
    end else begin
      state  <= state_next;
      eval_q <= (state == S_SCAN);

      // Passing check: clear marks and runtimes, count down the settle phase.
      if (state == S_IDLE && accept && !halted && is_check && pass) begin
        entered_mark <= '0;
        rt_valid     <= '0;
        if (settle_left != 2'd0) begin
          settle_left <= settle_left - 2'd1;
        end
      end

      if (state == S_REP_WR) begin
        row_valid[it_id]    <= 1'b1;
        rt_valid[it_id]     <= 1'b1;
        demoted_flag[it_id] <= it_demoted;
        if (it_entered) begin
          entered_mark[it_id] <= 1'b1;
        end
      end

      if (state == S_FIX_WR) begin
        row_valid[blame_q] <= 1'b1;
      end

      // Hand the pending result to the output register; a fault halts.
      if (state == S_OUT && out_free) begin
        m_tvalid <= 1'b1;
        halted   <= res.fault;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end

      // Writes must arrive only while idle; the block itself does not enforce it.
      if (cfg_we) begin
        unique case (tlw_pkg::cfg_idx_t'(cfg_addr))
          tlw_pkg::CFG_MAX_RUNTIME:   max_runtime <= cfg_wdata;
          tlw_pkg::CFG_MAX_ELAPSED:   max_elapsed <= cfg_wdata;
          tlw_pkg::CFG_SETTLE_CHECKS: settle_left <= cfg_wdata[1:0];
          default: ;
        endcase
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (state == S_IDLE && accept) begin
      it_id      <= id_addr;
      it_entered <= in_item.entered;
      it_runtime <= in_item.runtime_value;
      it_start   <= in_item.enter_tick;
      it_demoted <= in_item.demoted;
      now_q      <= in_item.now_tick;
      scan_idx   <= '0;
    end else if (state == S_SCAN) begin
      scan_idx <= scan_idx + AW'(1);
    end

    eval_idx_q <= scan_idx;

    if (state == S_IDLE && accept) begin
      res <= '{pad: 1'b0, error_total: 8'd0, task_number: 3'd0,
               fault_kind: tlw_pkg::KIND_NONE, fault: 1'b0, refresh: 1'b1};
    end else if (state == S_DECIDE) begin
      blame_q <= blame_idx;
      kind_q  <= hits.ovr ? tlw_pkg::KIND_OVERRUN : tlw_pkg::KIND_STALL;
      res <= '{pad: 1'b0, error_total: 8'd0, task_number: 3'd0,
               fault_kind: tlw_pkg::KIND_NO_CULPRIT, fault: 1'b1, refresh: 1'b0};
    end else if (state == S_FIX_WR) begin
      res <= '{pad: 1'b0, error_total: err_inc,
               task_number: tlw_pkg::NUM_W'(32'(blame_q) + 32'd1),
               fault_kind: kind_q, fault: 1'b1, refresh: 1'b0};
    end

    if (state == S_OUT && out_free) begin
      out_q <= res;
    end
  end

  // The fault result is loaded on the same edge that halts the block.
  a_halt_with_fault: assert property (@(posedge clk) disable iff (rst)
    $rose(halted) |-> m_tvalid && out_q.fault)
    else $error("halt without a fault result");

  // Halt holds until reset.
  a_halt_sticky: assert property (@(posedge clk) disable iff (rst)
    halted |=> halted)
    else $error("halt released without reset");

  // Record RAM is written only by a report merge or an error-count write-back.
  a_ram_write_src: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == S_REP_WR || state == S_FIX_WR))
    else $error("unexpected record write");

  // The write-back follows the read issued in the decide step.
  a_fix_after_decide: assert property (@(posedge clk) disable iff (rst)
    state == S_FIX_WR |-> $past(state) == S_DECIDE && $past(hits.ovr || hits.stl))
    else $error("error write-back without a blamed task");

endmodule

// ===== test/task_liveness_watchdog_monitor_unit_tb.sv =====
module task_liveness_watchdog_monitor_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TASKS       = 5;
  localparam int HOLD_CYCLES = 300;   // long receiver hold-off in the pressure test
  localparam int STUCK_LIMIT = 4000;  // cycles with no item moving before giving up

  // Block ports
  logic                           clk       = 1'b0;
  logic                           rst       = 1'b1;
  logic                           s_tvalid  = 1'b0;
  logic                           s_tready;
  // task_id, entered, runtime_value, enter_tick, demoted, now_tick, zero fill
  logic [tlw_pkg::IN_DATA_W-1:0]  s_tdata   = '0;
  // req_type
  logic                           s_tuser   = 1'b0;
  logic                           m_tvalid;
  logic                           m_tready  = 1'b0;
  // refresh, fault, fault_kind, task_number, error_total, zero fill
  logic [tlw_pkg::OUT_DATA_W-1:0] m_tdata;
  logic                           cfg_we    = 1'b0;
  logic [1:0]                     cfg_addr  = '0;
  logic [31:0]                    cfg_wdata = '0;

  // Watchdog predictor state: one record per task plus the limits and the
  // settle/halt flags, updated by accepted items and register writes.
  bit          entered_now [TASKS];
  logic [31:0] last_run    [TASKS];
  logic [31:0] start_at    [TASKS];
  bit          benched     [TASKS];
  logic [7:0]  blame_cnt   [TASKS];
  logic [31:0] lim_runtime   = tlw_pkg::RST_MAX_RUNTIME;
  logic [31:0] lim_elapsed   = tlw_pkg::RST_MAX_ELAPSED;
  logic [1:0]  settle_left_p = tlw_pkg::RST_SETTLE;
  bit          halted_p      = 1'b0;

  // Verdicts predicted for accepted checks, oldest first
  tlw_pkg::out_item_t verdict_q [$];
  tlw_pkg::out_item_t result_due, result_seen;

  int          fail_count   = 0;
  int          items_sent   = 0;
  int unsigned send_burst   = 0;
  int          stuck_cycles = 0;

  // Receiver side pacing
  bit          hold_go    = 1'b0;
  bit          hold_seen  = 1'b0;
  int          hold_left  = 0;
  int unsigned sink_burst = 0;
  int unsigned sink_stall = 0;
  int unsigned sink_roll;

  task_liveness_watchdog_monitor_unit #(
    .TASKS(TASKS)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // Apply one register write to the predictor; the settle write also reloads
  // the count of start-up checks left.
  function automatic void apply_reg(tlw_pkg::cfg_idx_t idx, logic [31:0] val);
    case (idx)
      tlw_pkg::CFG_MAX_RUNTIME:   lim_runtime = val;
      tlw_pkg::CFG_MAX_ELAPSED:   lim_elapsed = val;
      tlw_pkg::CFG_SETTLE_CHECKS: settle_left_p = val[1:0];
      default: ;
    endcase
  endfunction

  // Work out what one accepted item does to the task records and queue the
  // verdict of a health check.
  function automatic void judge_item(bit is_check, tlw_pkg::in_item_t it);
    tlw_pkg::out_item_t v;
    bit                 pass;
    int                 blamed;
    tlw_pkg::kind_t     kind;
    logic [31:0]        elapsed;
    v      = '0;
    blamed = -1;
    kind   = tlw_pkg::KIND_NO_CULPRIT;
    // once halted, every item is swallowed
    if (halted_p) return;
    if (!is_check) begin
      // reports for indexes past the last task are dropped
      if (it.task_id >= TASKS) return;
      if (it.entered) begin
        entered_now[it.task_id] = 1'b1;
        start_at[it.task_id]    = it.enter_tick;
      end
      last_run[it.task_id] = it.runtime_value;
      benched[it.task_id]  = it.demoted;
      return;
    end
    pass = 1'b1;
    for (int i = 0; i < TASKS; i++)
      if (!entered_now[i] && !benched[i]) pass = 1'b0;
    if (settle_left_p != 0) pass = 1'b1;
    if (pass) begin
      if (settle_left_p != 0) settle_left_p--;
      for (int i = 0; i < TASKS; i++) begin
        entered_now[i] = 1'b0;
        last_run[i]    = '0;
      end
      v.refresh = 1'b1;
      verdict_q.push_back(v);
      return;
    end
    // overrun takes priority over a stall; lowest task index wins within each
    for (int i = 0; i < TASKS; i++)
      if (blamed < 0 && !benched[i] && last_run[i] > lim_runtime) begin
        blamed = i;
        kind   = tlw_pkg::KIND_OVERRUN;
      end
    for (int i = 0; i < TASKS; i++) begin
      elapsed = it.now_tick - start_at[i];  // wraps modulo 2^32
      if (blamed < 0 && !benched[i] && elapsed > lim_elapsed) begin
        blamed = i;
        kind   = tlw_pkg::KIND_STALL;
      end
    end
    halted_p     = 1'b1;
    v.fault      = 1'b1;
    v.fault_kind = kind;
    if (blamed >= 0) begin
      if (blame_cnt[blamed] != tlw_pkg::ERR_MAX) blame_cnt[blamed]++;
      v.task_number = 3'(blamed + 1);
      v.error_total = blame_cnt[blamed];
    end
    verdict_q.push_back(v);
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Mostly short gaps, a few long ones, and now and then a gapless stretch.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    if (send_burst != 0) begin
      send_burst--;
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 2) begin
      send_burst = $urandom_range(20, 80);
      return 0;
    end
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Tick values biased toward the ends of the range.
  function automatic logic [31:0] rand_tick();
    case ($urandom_range(0, 7))
      0:       return 32'hFFFF_FFFF - $urandom_range(0, 15);
      1, 2:    return $urandom_range(0, 63);
      default: return $urandom();
    endcase
  endfunction

  function automatic tlw_pkg::in_item_t make_report(logic [2:0] id, bit ent,
                                                    logic [31:0] run,
                                                    logic [31:0] start, bit dem);
    tlw_pkg::in_item_t it;
    it               = '0;
    it.task_id       = id;
    it.entered       = ent;
    it.runtime_value = run;
    it.enter_tick    = start;
    it.demoted       = dem;
    it.now_tick      = $urandom();  // unused by a report, keep it noisy
    return it;
  endfunction

  // A check carries random noise in every field except the current tick and the zero fill.
  function automatic tlw_pkg::in_item_t make_check(logic [31:0] now);
    tlw_pkg::in_item_t it;
    it = make_report(3'($urandom_range(0, 7)), $urandom_range(0, 1) != 0, $urandom(),
                     $urandom(), $urandom_range(0, 1) != 0);
    it.now_tick = now;
    return it;
  endfunction

  function automatic tlw_pkg::in_item_t random_report();
    logic [2:0] id;
    id = ($urandom_range(0, 9) != 0) ? 3'($urandom_range(0, TASKS - 1))
                                     : 3'($urandom_range(TASKS, 7));
    return make_report(id, $urandom_range(0, 3) != 0, rand_tick(), rand_tick(),
                       $urandom_range(0, 6) == 0);
  endfunction

  // Offer one item, hold it until accepted, predict, then idle for a picked gap, if any.
  task automatic send_item(bit is_check, tlw_pkg::in_item_t it);
    int unsigned gap;
    s_tvalid <= 1'b1;
    s_tuser  <= is_check;
    s_tdata  <= it;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    judge_item(is_check, it);
    if (is_check || it.task_id < TASKS) items_sent++;
    gap = pick_gap();
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Once the start-up checks are used up, report every missing task first so
  // that the check passes and the block keeps running.
  task automatic send_passing_check(logic [31:0] now);
    if (settle_left_p == 0) begin
      for (int i = 0; i < TASKS; i++)
        if (!entered_now[i] && !benched[i])
          send_item(1'b0, make_report(3'(i), 1'b1, rand_tick(), rand_tick(), 1'b0));
    end
    send_item(1'b1, make_check(now));
  endtask

  // A period: a handful of reports, then a check.
  task automatic run_period();
    repeat ($urandom_range(0, 8)) send_item(1'b0, random_report());
    send_passing_check(rand_tick());
  endtask

  // Drop valid, wait for every verdict, then let a failing scan run out.
  task automatic wait_for_quiet();
    s_tvalid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (TASKS + 8) @(posedge clk);
  endtask

  // Write the three limits back to back; optionally poke the unused index too.
  task automatic program_limits(logic [31:0] rt, logic [31:0] el, logic [1:0] st,
                                bit poke_unused);
    tlw_pkg::cfg_idx_t idx [4];
    logic [31:0]       val [4];
    int                n;
    idx[0] = tlw_pkg::CFG_MAX_RUNTIME;   val[0] = rt;
    idx[1] = tlw_pkg::CFG_MAX_ELAPSED;   val[1] = el;
    // upper bits of the settle write carry junk that must be ignored
    idx[2] = tlw_pkg::CFG_SETTLE_CHECKS; val[2] = ($urandom() & 32'hFFFF_FFFC) | st;
    idx[3] = tlw_pkg::CFG_UNUSED;        val[3] = $urandom();
    n = poke_unused ? 4 : 3;
    for (int k = 0; k < n; k++) begin
      cfg_we    <= 1'b1;
      cfg_addr  <= idx[k];
      cfg_wdata <= val[k];
      @(posedge clk);
      apply_reg(idx[k], val[k]);
    end
    cfg_we <= 1'b0;
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      fail_count++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Start-up checks pass whatever the records say; cover field extremes,
  // out-of-range task indexes and a report that leaves its entered mark alone.
  task automatic test_directed_startup();
    send_item(1'b0, make_report(3'd0, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0));
    send_item(1'b0, make_report(3'd4, 1'b0, 32'h0, 32'h0, 1'b1));
    send_item(1'b0, make_report(3'd7, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1));
    send_item(1'b0, make_report(3'd5, 1'b1, 32'h0, 32'h0, 1'b0));
    send_item(1'b0, make_report(3'd6, 1'b0, 32'h5A5A_A5A5, 32'hA5A5_5A5A, 1'b1));
    send_item(1'b0, make_report(3'd1, 1'b1, 32'd5, 32'h0000_1234, 1'b0));
    // entered clear: start tick and entered mark stay as they were
    send_item(1'b0, make_report(3'd1, 1'b0, 32'd7, 32'hFFFF_0000, 1'b0));
    send_item(1'b1, make_check(32'h0));
    send_item(1'b1, make_check(32'hFFFF_FFFF));
    send_item(1'b1, make_check(rand_tick()));
    // settle count now spent: every task entered or demoted passes
    send_item(1'b0, make_report(3'd0, 1'b1, 32'd0, 32'hFFFF_FFF0, 1'b0));
    send_item(1'b0, make_report(3'd1, 1'b1, 32'd3, 32'h0000_0010, 1'b0));
    send_item(1'b0, make_report(3'd2, 1'b1, 32'd10, 32'h8000_0000, 1'b0));
    send_item(1'b0, make_report(3'd3, 1'b1, 32'd11, 32'h7FFF_FFFF, 1'b0));
    send_item(1'b1, make_check(32'h0000_0020));
    send_passing_check(32'h0);
  endtask

  // Sweep the limits through their extremes and random values; each setting
  // gets at least 205 items of random report/check periods.
  task automatic test_random_periods();
    logic [31:0] rt, el;
    logic [1:0]  st;
    int          target;
    for (int ph = 0; ph < 6; ph++) begin
      wait_for_quiet();
      case (ph)
        0: begin rt = '0; el = '0; st = 2'd0; end
        1: begin rt = '1; el = '1; st = 2'd3; end
        2: begin rt = $urandom(); el = $urandom(); st = 2'd1; end
        3: begin rt = $urandom_range(0, 20); el = $urandom_range(0, 100); st = 2'd2; end
        4: begin rt = $urandom(); el = $urandom_range(0, 100); st = 2'($urandom()); end
        default: begin rt = $urandom_range(0, 20); el = $urandom(); st = 2'($urandom()); end
      endcase
      program_limits(rt, el, st, ph == 0);
      target = items_sent + 205;
      while (items_sent < target) run_period();
    end
  endtask

  // Hold the receiver off for a long stretch while checks keep coming, so the
  // output fills and the input stalls.
  task automatic test_output_backpressure();
    wait_for_quiet();
    program_limits(lim_runtime, lim_elapsed, 2'd3, 1'b0);
    send_burst = 1000;
    hold_go <= ~hold_go;
    repeat (16) send_passing_check(rand_tick());
    send_burst = 0;
  endtask

  // One failing check, aimed at a random fault kind; afterwards the block is
  // halted and nothing it is fed may produce a result.
  task automatic test_fault_and_halt();
    tlw_pkg::kind_t aim;
    logic [31:0]    rt, el, now, run, start;
    int             victim, culprit;
    bit             dem;
    wait_for_quiet();
    case ($urandom_range(0, 2))
      0: begin aim = tlw_pkg::KIND_OVERRUN; rt = $urandom_range(0, 1000); el = $urandom(); end
      1: begin aim = tlw_pkg::KIND_STALL; rt = '1; el = $urandom_range(0, 1000); end
      default: begin aim = tlw_pkg::KIND_NO_CULPRIT; rt = '1; el = '1; end
    endcase
    program_limits(rt, el, 2'd0, 1'b0);
    victim  = $urandom_range(0, TASKS - 1);
    culprit = (victim + $urandom_range(1, TASKS - 1)) % TASKS;
    // small ticks force the elapsed subtraction to wrap
    now = $urandom_range(0, 1) ? 32'($urandom_range(0, 40)) : 32'($urandom());
    for (int i = 0; i < TASKS; i++) begin
      dem   = (i != victim) && (i != culprit) && ($urandom_range(0, 4) == 0);
      run   = (aim == tlw_pkg::KIND_OVERRUN && i == culprit)
              ? rt + 1 + $urandom_range(0, 1000) : $urandom_range(0, rt);
      start = (aim == tlw_pkg::KIND_STALL && i == culprit)
              ? now - el - 1 - $urandom_range(0, 50) : now - $urandom_range(0, el);
      // the victim never enters, so the check has to fail
      send_item(1'b0, make_report(3'(i), i != victim, run, start, dem));
    end
    send_item(1'b1, make_check(now));
    wait_for_quiet();
    // register writes still land while halted
    program_limits($urandom(), $urandom(), 2'd3, 1'b0);
    repeat (10) begin
      if ($urandom_range(0, 1) != 0) send_item(1'b1, make_check(rand_tick()));
      else send_item(1'b0, random_report());
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequencing
  // ---------------------------------------------------------------------------

  initial begin
    for (int i = 0; i < TASKS; i++) begin
      entered_now[i] = 1'b0;
      last_run[i]    = '0;
      start_at[i]    = '0;
      benched[i]     = 1'b0;
      blame_cnt[i]   = '0;
    end
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    test_directed_startup();
    test_random_periods();
    test_output_backpressure();
    test_fault_and_halt();

    // drain and give a trailing scan time to show up as a stray result
    wait_for_quiet();
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Receiver: a requested hold-off wins, then gapless stretches, then random
  // stalls, mostly short and a few long.
  always @(posedge clk) begin
    if (hold_go != hold_seen) begin
      hold_seen <= hold_go;
      hold_left <= HOLD_CYCLES;
      m_tready  <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_tready  <= 1'b0;
    end else if (sink_burst != 0) begin
      sink_burst <= sink_burst - 1;
      m_tready   <= 1'b1;
    end else if (sink_stall != 0) begin
      sink_stall <= sink_stall - 1;
      m_tready   <= 1'b0;
    end else begin
      sink_roll = $urandom_range(0, 99);
      if (sink_roll < 3) begin
        sink_burst <= $urandom_range(20, 80);
        m_tready   <= 1'b1;
      end else if (sink_roll < 70) begin
        m_tready <= 1'b1;
      end else if (sink_roll < 95) begin
        sink_stall <= $urandom_range(0, 2);
        m_tready   <= 1'b0;
      end else begin
        sink_stall <= $urandom_range(8, 40);
        m_tready   <= 1'b0;
      end
    end
  end

  // Compare each accepted result with the oldest predicted verdict.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      result_seen = m_tdata;
      if (verdict_q.size() == 0) begin
        $display("%0t: result with no verdict waiting, expected none, actual %h",
                 $time, m_tdata);
        fail_count++;
      end else begin
        result_due = verdict_q.pop_front();
        check_field("refresh", result_due.refresh, result_seen.refresh);
        check_field("fault", result_due.fault, result_seen.fault);
        check_field("fault_kind", result_due.fault_kind, result_seen.fault_kind);
        check_field("task_number", result_due.task_number, result_seen.task_number);
        check_field("error_total", result_due.error_total, result_seen.error_total);
      end
    end
  end

  // Give up if no item moves on either side for too long.
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

endmodule
